FILE: hw/rtl/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg
// shared types and codes for the reset line monitor
// ----------------------------------------------------------------------------
package rlm_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_RESET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_RESET  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DETECT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REBOOT_QUIET = 8'd3;

  localparam logic [CFG_DATA_W-1:0] SHORT_RESET_RST  = 16'd400;
  localparam logic [CFG_DATA_W-1:0] LONG_RESET_RST   = 16'd2500;
  localparam logic [CFG_DATA_W-1:0] LONG_DETECT_RST  = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] REBOOT_QUIET_RST = 16'd5000;

  // item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_DRIVE = 1'b1;

  // line event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_ENTERED     = 3'd1;
  localparam logic [2:0] EV_OUT         = 3'd2;
  localparam logic [2:0] EV_POWERED_ON  = 3'd3;
  localparam logic [2:0] EV_LONG_RESET  = 3'd4;
  localparam logic [2:0] EV_POWERED_OFF = 3'd5;

  // line state codes (bit 1 set means level not yet known)
  localparam logic [1:0] LS_LOW     = 2'd0;
  localparam logic [1:0] LS_HIGH    = 2'd1;
  localparam logic [1:0] LS_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] short_reset_ms;
    logic [CFG_DATA_W-1:0] long_reset_ms;
    logic [CFG_DATA_W-1:0] long_detect_ms;
    logic [CFG_DATA_W-1:0] reboot_quiet_ms;
  } cfg_t;

  typedef struct packed {
    logic opcode;
    logic hold;
    logic long_request;
    logic line_level;
    logic reboot_seen;
    logic sense_high;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic [2:0] line_event;
    logic       reboot_event;
  } out_item_t;

  // flag state of the monitor
  typedef struct packed {
    logic [1:0] line_state;
    logic       was_powered_off;
    logic       drive_active;
    logic       release_armed;
    logic       long_armed;
    logic       long_held;
  } flags_t;

endpackage

FILE: hw/rtl/reset_line_monitor.sv
// ----------------------------------------------------------------------------
// reset_line_monitor
// watches a host reset line on millisecond ticks, drives it low on command
// ----------------------------------------------------------------------------
// an accepted item is held in the input register until the result register is free;
// its result is then captured in the result register and held there until taken
// throughput: one item per cycle, sustained while results are taken
// input register, then update logic, then result register
// reset: async active low; line state unknown, all countdowns elapsed,
// timing registers back to 400 / 2500 / 2000 / 5000 ms
module reset_line_monitor #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rlm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rlm_pkg::in_item_t              in_data_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rlm_pkg::out_item_t             out_data_o
);
  import rlm_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q, result;
  logic      out_valid_q, out_valid_d;
  logic      out_free;   // result register can take a new item this cycle
  logic      fire;       // input register item is processed this cycle

  rlm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // stall travels back from the output: the input register only holds
  // its item when the result register is full and not being taken
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  assign in_valid_d  = (in_valid_i && in_ready_o) ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // state update and result for the item in the input register
  rlm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/rlm_cfg_regs.sv
// ----------------------------------------------------------------------------
// rlm_cfg_regs
// timing registers written through the plain configuration port
// ----------------------------------------------------------------------------
module rlm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rlm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output rlm_pkg::cfg_t                 cfg_o
);
  import rlm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SHORT_RESET:  cfg_d.short_reset_ms  = cfg_wdata_i;
        REG_LONG_RESET:   cfg_d.long_reset_ms   = cfg_wdata_i;
        REG_LONG_DETECT:  cfg_d.long_detect_ms  = cfg_wdata_i;
        REG_REBOOT_QUIET: cfg_d.reboot_quiet_ms = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_reset_ms  <= SHORT_RESET_RST;
      cfg_q.long_reset_ms   <= LONG_RESET_RST;
      cfg_q.long_detect_ms  <= LONG_DETECT_RST;
      cfg_q.reboot_quiet_ms <= REBOOT_QUIET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/rlm_core.sv
// ----------------------------------------------------------------------------
// rlm_core
// monitor state, countdowns and the per-item update logic
// ----------------------------------------------------------------------------
module rlm_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rlm_pkg::in_item_t item_i,
  input  rlm_pkg::cfg_t     cfg_i,
  output rlm_pkg::out_item_t result_o
);
  import rlm_pkg::*;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;
  localparam logic [TIMER_BITS-1:0] CNT_ZERO = '0;
  localparam logic [TIMER_BITS-1:0] CNT_ONE  = TIMER_BITS'(1);

  // clamp a register value to the countdown range
  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [CFG_DATA_W-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    sat_load = (w > TMAX) ? TMAX[TIMER_BITS-1:0] : w[TIMER_BITS-1:0];
  endfunction

  function automatic logic [TIMER_BITS-1:0] dec(input logic [TIMER_BITS-1:0] c);
    dec = (c != CNT_ZERO) ? c - CNT_ONE : CNT_ZERO;
  endfunction

  flags_t                flags_q, flags_d;
  logic [TIMER_BITS-1:0] release_cnt_q, release_cnt_d;
  logic [TIMER_BITS-1:0] long_cnt_q, long_cnt_d;
  logic [TIMER_BITS-1:0] reboot_cnt_q, reboot_cnt_d;
  logic [TIMER_BITS-1:0] rel_dec, long_dec, reb_dec, quiet_load;
  logic [2:0]            ev;
  logic                  reboot_ev;

  always_comb begin
    flags_d       = flags_q;
    release_cnt_d = release_cnt_q;
    long_cnt_d    = long_cnt_q;
    reboot_cnt_d  = reboot_cnt_q;
    ev            = EV_NONE;
    reboot_ev     = 1'b0;
    rel_dec       = dec(release_cnt_q);
    long_dec      = dec(long_cnt_q);
    reb_dec       = dec(reboot_cnt_q);
    quiet_load    = sat_load(cfg_i.reboot_quiet_ms);

    if (item_i.opcode == OP_DRIVE) begin
      flags_d.drive_active = 1'b1;
      if (item_i.hold) begin
        flags_d.release_armed = 1'b0;
        flags_d.long_armed    = 1'b0;
        flags_d.long_held     = 1'b1;
        release_cnt_d         = CNT_ZERO;
        long_cnt_d            = CNT_ZERO;
      end else begin
        flags_d.release_armed = 1'b1;
        release_cnt_d = item_i.long_request ? sat_load(cfg_i.long_reset_ms)
                                            : sat_load(cfg_i.short_reset_ms);
      end
    end else begin
      release_cnt_d = rel_dec;
      long_cnt_d    = long_dec;
      reboot_cnt_d  = reb_dec;

      if (flags_q.release_armed && rel_dec == CNT_ZERO) begin
        flags_d.release_armed = 1'b0;
        flags_d.drive_active  = 1'b0;
      end
      if (item_i.reboot_seen && reb_dec == CNT_ZERO) begin
        reboot_ev    = 1'b1;
        reboot_cnt_d = quiet_load;
      end

      priority if (flags_q.line_state[1]) begin
        flags_d.line_state = {1'b0, item_i.line_level};
      end else if (flags_q.line_state[0] != item_i.line_level) begin
        flags_d.line_state = {1'b0, item_i.line_level};
        if (!item_i.line_level) begin
          ev = EV_ENTERED;
          if (!flags_q.long_armed && !flags_q.long_held) begin
            flags_d.long_armed = 1'b1;
            long_cnt_d         = sat_load(cfg_i.long_detect_ms);
          end
        end else if (flags_q.was_powered_off) begin
          flags_d.was_powered_off = 1'b0;
          ev = EV_POWERED_ON;
        end else begin
          ev = EV_OUT;
        end
        reboot_cnt_d = quiet_load;
      end else if (flags_q.long_armed && long_dec == CNT_ZERO) begin
        flags_d.long_armed = 1'b0;
        if (flags_q.line_state == LS_LOW) begin
          if (item_i.sense_high) begin
            ev = EV_LONG_RESET;
          end else begin
            ev = EV_POWERED_OFF;
            flags_d.was_powered_off = 1'b1;
          end
        end
      end else begin
        flags_d.line_state = flags_q.line_state;
      end
    end

    result_o.drive_low    = flags_d.drive_active;
    result_o.line_event   = ev;
    result_o.reboot_event = reboot_ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q.line_state      <= LS_UNKNOWN;
      flags_q.was_powered_off <= 1'b0;
      flags_q.drive_active    <= 1'b0;
      flags_q.release_armed   <= 1'b0;
      flags_q.long_armed      <= 1'b0;
      flags_q.long_held       <= 1'b0;
      release_cnt_q           <= CNT_ZERO;
      long_cnt_q              <= CNT_ZERO;
      reboot_cnt_q            <= CNT_ZERO;
    end else if (fire_i) begin
      flags_q       <= flags_d;
      release_cnt_q <= release_cnt_d;
      long_cnt_q    <= long_cnt_d;
      reboot_cnt_q  <= reboot_cnt_d;
    end
  end

endmodule

FILE: hw/rtl/rlm_checker.sv
// ----------------------------------------------------------------------------
// rlm_checker
// port level checks for the reset line monitor, bound to the top level
// ----------------------------------------------------------------------------
module rlm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rlm_pkg::out_item_t out_data_o
);
  import rlm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // only defined event codes come out
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.line_event <= EV_POWERED_OFF)
    else $error("undefined line event code");

  // input back-pressure only comes from a blocked output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // a fresh result follows an earlier accepted item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching item");

endmodule

bind reset_line_monitor rlm_checker u_rlm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
